@@ hw/rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CELL_ADDR_W = 15;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [3:0]  MAX_TAB     = 4'd8;
  localparam logic [7:0]  RESET_ATTR  = 8'h0F;
  localparam logic [3:0]  RESET_TAB   = 4'd4;
  localparam logic [15:0] RESET_BLANK = 16'h0F20;

  localparam logic REG_ATTR = 1'b0;
  localparam logic REG_TAB  = 1'b1;

  typedef struct packed {
    logic [7:0] attr;
    logic [3:0] tab;
  } tcw_cfg_t;

  typedef struct packed {
    logic                   en;
    logic                   we;
    logic [CELL_ADDR_W-1:0] addr;
    logic [15:0]            data;
  } tcw_mem_req_t;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [15:0] cell_value;
  } tcw_result_t;

endpackage
`default_nettype wire

@@ hw/rtl/tcw_screen_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Single-port cell store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000
) (
  input  wire logic         clk,
  input  wire tcw_mem_req_t req,
  output logic [15:0]       rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        cells[req.addr[AW-1:0]] <= req.data;
      end else begin
        rdata <= cells[req.addr[AW-1:0]];
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tcw_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq
// Cursor, scroll offset and request sequencer; drives the cell store.
// ----------------------------------------------------------------------------
module tcw_seq
  import tcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire tcw_cfg_t     cfg,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   opcode,
  input  wire logic [7:0]   char_code,
  input  wire logic [4:0]   read_row,
  input  wire logic [6:0]   read_col,
  output tcw_mem_req_t      mem_req,
  input  wire logic [15:0]  mem_rdata,
  output logic              res_valid,
  input  wire logic         res_ready,
  output tcw_result_t       res
);

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_GLYPH, S_RDWAIT, S_SWEEP, S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    SW_RESET, SW_CLEAR, SW_SCROLL
  } sweep_t;

  state_t           state;
  sweep_t           sweep_kind;
  logic [1:0]       op_q;
  logic [7:0]       ch_q;
  logic [4:0]       rr_q;
  logic [6:0]       rc_q;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] top;
  logic [3:0]       tab_left;
  logic [15:0]      cell_q;
  logic             rd_ok;
  logic [ROW_W-1:0] sweep_row;
  logic [COL_W-1:0] sweep_col;
  logic [15:0]      sweep_data;

  logic [COL_W:0]   col_inc;
  logic [COL_W-1:0] col_dec;
  logic             wrap;
  logic             last_row;
  logic             printable;
  logic             glyph_go;
  logic [7:0]       glyph_ch;
  logic [15:0]      blank;
  logic             rd_in;
  logic [3:0]       tab_n;
  logic [3:0]       left_after;
  state_t           glyph_done;
  logic [ROW_W-1:0] top_inc;
  logic             accept;

  // logical row to physical row through the scroll offset
  function automatic logic [7:0] phys_row(input logic [7:0] lrow, input logic [7:0] top_r);
    logic [8:0] s;
    s = {1'b0, lrow} + {1'b0, top_r};
    if (s >= 9'(SCREEN_HEIGHT)) s = s - 9'(SCREEN_HEIGHT);
    return s[7:0];
  endfunction

  function automatic logic [CELL_ADDR_W-1:0] cell_addr(input logic [7:0] prow,
                                                        input logic [7:0] pcol);
    return CELL_ADDR_W'(prow) * CELL_ADDR_W'(SCREEN_WIDTH) + CELL_ADDR_W'(pcol);
  endfunction

  always_comb begin
    col_inc    = {1'b0, col} + (COL_W+1)'(1);
    col_dec    = col - COL_W'(1);
    wrap       = (col_inc == (COL_W+1)'(SCREEN_WIDTH));
    last_row   = (row == ROW_W'(SCREEN_HEIGHT - 1));
    printable  = (op_q == OP_PUT) && (ch_q != CH_BS) && (ch_q != CH_TAB) &&
                 (ch_q != CH_LF) && (ch_q != CH_CR);
    glyph_go   = (state == S_GLYPH) || ((state == S_EXEC) && printable);
    glyph_ch   = (state == S_GLYPH) ? CH_SPACE : ch_q;
    blank      = {cfg.attr, CH_SPACE};
    rd_in      = (32'(rr_q) < 32'(SCREEN_HEIGHT)) && (32'(rc_q) < 32'(SCREEN_WIDTH));
    tab_n      = (cfg.tab > MAX_TAB) ? MAX_TAB : cfg.tab;
    left_after = (state == S_GLYPH) ? (tab_left - 4'd1) : 4'd0;
    glyph_done = (left_after != 4'd0) ? S_GLYPH : S_RESULT;
    top_inc    = (top == ROW_W'(SCREEN_HEIGHT - 1)) ? '0 : (top + ROW_W'(1));
    in_ready   = (state == S_IDLE) || ((state == S_RESULT) && res_ready);
    accept     = in_valid && in_ready;
  end

  always_comb begin
    mem_req = '0;
    unique case (state)
      S_EXEC: begin
        if (glyph_go) begin
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = cell_addr(phys_row(8'(row), 8'(top)), 8'(col));
          mem_req.data = {cfg.attr, glyph_ch};
        end else if ((op_q == OP_PUT) && (ch_q == CH_BS) && (col != '0)) begin
          mem_req.en   = 1'b1;
          mem_req.we   = 1'b1;
          mem_req.addr = cell_addr(phys_row(8'(row), 8'(top)), 8'(col_dec));
          mem_req.data = blank;
        end else if ((op_q == OP_READ) && rd_in) begin
          mem_req.en   = 1'b1;
          mem_req.addr = cell_addr(phys_row(8'(rr_q), 8'(top)), 8'(rc_q));
        end
      end
      S_GLYPH: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = cell_addr(phys_row(8'(row), 8'(top)), 8'(col));
        mem_req.data = {cfg.attr, glyph_ch};
      end
      S_SWEEP: begin
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = cell_addr(8'(sweep_row), 8'(sweep_col));
        mem_req.data = sweep_data;
      end
      default: begin
      end
    endcase
  end

  assign res_valid      = (state == S_RESULT);
  assign res.cell_value = cell_q;
  assign res.row        = 5'(row);
  assign res.col        = 7'(col);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_kind <= SW_RESET;
      sweep_row  <= '0;
      sweep_col  <= '0;
      sweep_data <= RESET_BLANK;
      row        <= '0;
      col        <= '0;
      top        <= '0;
      tab_left   <= '0;
    end else begin
      if (accept) begin
        op_q <= opcode;
        ch_q <= char_code;
        rr_q <= read_row;
        rc_q <= read_col;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_EXEC;
        end
        S_EXEC, S_GLYPH: begin
          if (state == S_EXEC) cell_q <= '0;
          if (glyph_go) begin
            tab_left <= left_after;
            if (wrap) begin
              col <= '0;
              if (last_row) begin
                sweep_kind <= SW_SCROLL;
                sweep_row  <= top;
                sweep_col  <= '0;
                sweep_data <= blank;
                top        <= top_inc;
                state      <= S_SWEEP;
              end else begin
                row   <= row + ROW_W'(1);
                state <= glyph_done;
              end
            end else begin
              col   <= col_inc[COL_W-1:0];
              state <= glyph_done;
            end
          end else if (op_q == OP_PUT) begin
            state <= S_RESULT;
            case (ch_q)
              CH_LF: begin
                col <= '0;
                if (last_row) begin
                  sweep_kind <= SW_SCROLL;
                  sweep_row  <= top;
                  sweep_col  <= '0;
                  sweep_data <= blank;
                  top        <= top_inc;
                  state      <= S_SWEEP;
                end else begin
                  row <= row + ROW_W'(1);
                end
              end
              CH_CR: col <= '0;
              CH_TAB: begin
                if (tab_n != 4'd0) begin
                  tab_left <= tab_n;
                  state    <= S_GLYPH;
                end
              end
              CH_BS: begin
                if (col != '0) col <= col_dec;
              end
              default: begin
              end
            endcase
          end else if (op_q == OP_CLEAR) begin
            sweep_kind <= SW_CLEAR;
            sweep_row  <= '0;
            sweep_col  <= '0;
            sweep_data <= blank;
            top        <= '0;
            row        <= '0;
            col        <= '0;
            state      <= S_SWEEP;
          end else if (op_q == OP_READ) begin
            rd_ok <= rd_in;
            state <= S_RDWAIT;
          end else begin
            state <= S_RESULT;
          end
        end
        S_RDWAIT: begin
          cell_q <= rd_ok ? mem_rdata : 16'd0;
          state  <= S_RESULT;
        end
        S_SWEEP: begin
          sweep_col <= sweep_col + COL_W'(1);
          if (sweep_col == COL_W'(SCREEN_WIDTH - 1)) begin
            sweep_col <= '0;
            if ((sweep_kind == SW_SCROLL) || (sweep_row == ROW_W'(SCREEN_HEIGHT - 1))) begin
              unique case (sweep_kind)
                SW_RESET:  state <= S_IDLE;
                SW_CLEAR:  state <= S_RESULT;
                SW_SCROLL: state <= (tab_left != 4'd0) ? S_GLYPH : S_RESULT;
                default:   state <= S_IDLE;
              endcase
            end else begin
              sweep_row <= sweep_row + ROW_W'(1);
            end
          end
        end
        S_RESULT: begin
          if (res_ready) state <= accept ? S_EXEC : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/text_console_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: put char, clear, read cell, with cursor and scroll.
// ----------------------------------------------------------------------------
// One request in flight at a time; each returns one result. Cells live in one
// single-port store, so every cell write takes its own access to it: a scroll
// re-bases the screen through a row offset and blanks the new bottom row, and
// clear blanks every cell. After reset the store is blanked before
// s_axis_tready rises; configuration writes are taken throughout.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // opcode, char_code, read_row, read_col
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata   // cell_value, cursor_row, cursor_col
);

  tcw_cfg_t     cfg;
  tcw_mem_req_t mem_req;
  logic [15:0]  mem_rdata;
  logic         res_valid;
  logic         res_ready;
  tcw_result_t  res;
  tcw_result_t  out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attr <= RESET_ATTR;
      cfg.tab  <= RESET_TAB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTR: cfg.attr <= cfg_data;
        REG_TAB:  cfg.tab  <= cfg_data[3:0];
        default:  cfg.attr <= cfg.attr;
      endcase
    end
  end

  tcw_screen_mem #(
    .DEPTH(SCREEN_WIDTH * SCREEN_HEIGHT)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  tcw_seq #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .opcode    (s_axis_tdata[1:0]),
    .char_code (s_axis_tdata[9:2]),
    .read_row  (s_axis_tdata[14:10]),
    .read_col  (s_axis_tdata[21:15]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register frees the sequencer while a result waits
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
    if (res_valid && res_ready) out_data <= res;
  end

  assign m_axis_tdata = {4'd0, out_data};

endmodule
`default_nettype wire

@@ hw/rtl/tcw_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // store is being blanked right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during reset clearing pass");

  // one request at a time: never ready in the cycle after a take
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken back to back");

  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((32'(m_axis_tdata[27:21]) < SCREEN_WIDTH) &&
                       (32'(m_axis_tdata[20:16]) < SCREEN_HEIGHT)))
    else $error("cursor outside screen");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:28] == 4'd0))
    else $error("result padding not zero");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/sv/text_console_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the request, result and register-write ports of the text console
// writer and keeps a shadow screen, cursor and register copy of its own.
// Every accepted request is applied to the shadow and the cursor report it
// implies is queued. Every accepted result is checked field by field against
// the oldest queued report. The failure tally and the number of reports still
// owed are handed to the top.
// ----------------------------------------------------------------------------
module text_console_checker
  import tcw_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 80,
  parameter int SCREEN_HEIGHT = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          mismatch_count,
  output int          reports_owed
);

  localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;

  logic [15:0] shadow_cells [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  attr_reg;
  logic [3:0]  tab_reg;
  int          fail_tally;
  tcw_result_t cursor_reports [$];

  function automatic logic [15:0] blank_cell();
    return {attr_reg, CH_SPACE};
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - SCREEN_WIDTH; i++)
      shadow_cells[i] = shadow_cells[i + SCREEN_WIDTH];
    for (int i = CELLS - SCREEN_WIDTH; i < CELLS; i++)
      shadow_cells[i] = blank_cell();
    cur_row = SCREEN_HEIGHT - 1;
    cur_col = 0;
  endfunction

  function automatic void advance_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= SCREEN_HEIGHT)
      scroll_screen();
  endfunction

  function automatic void write_glyph(input logic [7:0] ch);
    shadow_cells[cur_row * SCREEN_WIDTH + cur_col] = {attr_reg, ch};
    cur_col++;
    if (cur_col >= SCREEN_WIDTH)
      advance_row();
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    int unsigned spaces;
    case (ch)
      CH_LF: advance_row();
      CH_CR: cur_col = 0;
      CH_TAB: begin
        // widths above the maximum are clamped
        spaces = 32'((tab_reg > MAX_TAB) ? MAX_TAB : tab_reg);
        repeat (spaces) write_glyph(CH_SPACE);
      end
      CH_BS: begin
        // never steps back onto the previous row
        if (cur_col > 0) begin
          cur_col--;
          shadow_cells[cur_row * SCREEN_WIDTH + cur_col] = blank_cell();
        end
      end
      default: write_glyph(ch);
    endcase
  endfunction

  function automatic tcw_result_t apply_request(input logic [23:0] req);
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [4:0]  rr;
    logic [6:0]  rc;
    tcw_result_t rep;
    op = req[1:0];
    ch = req[9:2];
    rr = req[14:10];
    rc = req[21:15];
    rep.cell_value = '0;
    case (op)
      OP_PUT: put_char(ch);
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++)
          shadow_cells[i] = blank_cell();
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        // reads off the screen return zero
        if (rr < SCREEN_HEIGHT && rc < SCREEN_WIDTH)
          rep.cell_value = shadow_cells[rr * SCREEN_WIDTH + rc];
      end
      default: ;
    endcase
    rep.row = cur_row[4:0];
    rep.col = cur_col[6:0];
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_tally++;
    end
  endfunction

  always @(posedge clk) begin : watch
    tcw_result_t got;
    tcw_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++)
        shadow_cells[i] = RESET_BLANK;
      cur_row = 0;
      cur_col = 0;
      attr_reg = RESET_ATTR;
      tab_reg = RESET_TAB;
      fail_tally = 0;
      cursor_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ATTR)
          attr_reg = cfg_data;
        else
          tab_reg = cfg_data[3:0];
      end
      // the result leaving now belongs to an older request than one arriving now
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[27:0];
        if (cursor_reports.size() == 0) begin
          $error("result with no request outstanding: %0h", m_axis_tdata);
          fail_tally++;
        end else begin
          want = cursor_reports.pop_front();
          check_field("cell_value", want.cell_value, got.cell_value);
          check_field("cursor_row", 16'(want.row), 16'(got.row));
          check_field("cursor_col", 16'(want.col), 16'(got.col));
          check_field("tdata padding", '0, 16'(m_axis_tdata[31:28]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        cursor_reports.push_back(apply_request(s_axis_tdata));
    end
    mismatch_count <= fail_tally;
    reports_owed <= cursor_reports.size();
  end

endmodule

@@ tb/sv/tb_text_console_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives the text console writer with a short directed set of requests and
// then random bursts of text lines, line feeds, cell reads and control
// characters over four back-pressure phases, with register changes between
// phases. Checking lives in text_console_checker; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int SCREEN_W       = 80;
  localparam int SCREEN_H       = 25;
  localparam int RANDOM_ITEMS   = 850;
  localparam int PHASES         = 4;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 20;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // opcode, char_code, read_row, read_col
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // cell_value, cursor_row, cursor_col

  int mismatch_count;
  int reports_owed;
  int requests_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_seq = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_writer #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  text_console_checker #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatch_count(mismatch_count),
    .reports_owed  (reports_owed)
  );

  // result side: a new hold_seq starts a long hold-off, otherwise random stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL text_console_writer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [23:0] pack_request(input logic [1:0] op, input logic [7:0] ch,
                                               input logic [4:0] rr, input logic [6:0] rc);
    return {2'b00, rc, rr, ch, op};
  endfunction

  task automatic send_request(input logic [23:0] req);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  // unused fields carry noise
  task automatic send_char(input logic [7:0] ch);
    send_request(pack_request(OP_PUT, ch, 5'($urandom_range(31)), 7'($urandom_range(127))));
  endtask

  task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
    send_request(pack_request(OP_READ, 8'($urandom_range(255)), rr, rc));
  endtask

  task automatic send_clear();
    send_request(pack_request(OP_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                              7'($urandom_range(127))));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] attr, input logic [3:0] tab);
    cfg_we <= 1'b1;
    cfg_index <= REG_ATTR;
    cfg_data <= attr;
    @(posedge clk);
    cfg_index <= REG_TAB;
    cfg_data <= {4'b0000, tab};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_text_char();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80)
      send_char(8'($urandom_range(8'h20, 8'h7E)));
    else if (pick < 88)
      send_char(8'($urandom_range(255)));
    else if (pick < 94)
      send_char(CH_TAB);
    else
      send_char(CH_BS);
  endtask

  task automatic random_burst();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 2) begin
      send_clear();
    end else if (kind < 47) begin
      // one line of text, now and then long enough to wrap
      len = ($urandom_range(9) == 0) ? $urandom_range(75, 100) : $urandom_range(20);
      repeat (len) send_text_char();
      if ($urandom_range(3) == 0)
        send_char(CH_CR);
      send_char(CH_LF);
    end else if (kind < 62) begin
      repeat ($urandom_range(1, 10)) send_char(CH_LF);
    end else if (kind < 87) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(99) < 85)
          read_cell(5'($urandom_range(SCREEN_H - 1)), 7'($urandom_range(SCREEN_W - 1)));
        else
          read_cell(5'($urandom_range(31)), 7'($urandom_range(127)));
      end
    end else begin
      case ($urandom_range(4))
        0: send_char(8'($urandom_range(255)));
        1: repeat ($urandom_range(1, 4)) send_char(CH_BS);
        2: send_char(CH_TAB);
        3: send_char(CH_CR);
        default: send_request(pack_request(OP_UNUSED, 8'($urandom_range(255)),
                                           5'($urandom_range(31)),
                                           7'($urandom_range(127))));
      endcase
    end
  endtask

  initial begin : stimulus
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset contents, corners, off-screen reads, control chars
    read_cell(5'd0, 7'd0);
    read_cell(5'd24, 7'd79);
    read_cell(5'd25, 7'd0);
    read_cell(5'd0, 7'd80);
    read_cell(5'd31, 7'd127);
    send_char(8'h41);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(8'h80);
    send_char(CH_BS);
    send_char(CH_BS);
    send_char(CH_TAB);
    read_cell(5'd0, 7'd3);
    send_char(CH_CR);
    send_char(CH_BS);
    send_char(CH_LF);
    send_request(pack_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127));
    read_cell(5'd0, 7'd0);
    send_clear();
    read_cell(5'd0, 7'd1);
    read_cell(5'd24, 7'd79);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          set_config(8'($urandom_range(255)), MAX_TAB);
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          // long hold-off on the result side while requests keep coming
          hold_len <= LONG_HOLD;
          hold_seq <= hold_seq + 1;
        end
        1: begin
          set_config(8'h00, 4'd0);
          tx_idle_pct = 55;
          rx_stall_pct <= 0;
        end
        2: begin
          set_config(8'hFF, 4'd15);
          tx_idle_pct = 0;
          rx_stall_pct <= 55;
        end
        default: begin
          set_config(8'($urandom_range(255)), 4'($urandom_range(1, 7)));
          tx_idle_pct = 23;
          rx_stall_pct <= 23;
        end
      endcase
      target = requests_sent + RANDOM_ITEMS / PHASES;
      while (requests_sent < target) random_burst();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS text_console_writer");
    else
      $display("FAIL text_console_writer");
    $finish;
  end

endmodule
